FILE: sv/bdll_pkg.sv
// Shared types and constants for the bounded doubly linked list.
// No dependencies; imported by every module of the block but bdll_ram.
package bdll_pkg;

  localparam int DEF_LIST_DEPTH = 64;
  localparam int NAME_BYTES     = 20;

  localparam int NAME_W     = 160;
  localparam int AGE_W      = 8;
  localparam int REC_W      = NAME_W + AGE_W;
  localparam int TDATA_W    = 168;
  localparam int IN_USER_W  = 2;
  localparam int OUT_USER_W = 4;

  // bytes past NAME_BYTES are forced to zero
  localparam logic [NAME_W-1:0] NAME_MASK = {NAME_W{1'b1}} >> (NAME_W - 8 * NAME_BYTES);

  typedef enum logic [1:0] {
    OP_HEAD_INS = 2'd0,
    OP_TAIL_INS = 2'd1,
    OP_DELETE   = 2'd2,
    OP_DUMP     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_DUMPED    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INS_WR,
    S_DEL_CMP,
    S_DEL_FREE,
    S_DMP_OUT,
    S_REPLY
  } state_t;

  typedef enum logic [1:0] {
    RD_FREE,
    RD_HEAD,
    RD_NEXT
  } rd_src_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    op_t  op;
    logic list_full;
    logic list_empty;
    logic match;
    logic walk_tail;
    logic out_free;
  } ctl_sts_t;

  // sequencer commands to the datapath
  typedef struct packed {
    logic    in_ready;
    logic    rd_en;
    rd_src_t rd_src;
    logic    idx_clr;
    logic    idx_inc;
    logic    do_insert;
    logic    do_unlink;
    logic    do_release;
    logic    load_out;
    logic    out_record;
    status_t out_status;
  } ctl_cmd_t;

endpackage

FILE: sv/bdll_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bdll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/bdll_ctrl.sv
// Sequencer for the linked list: decodes the opcode and steps the list walk.
// Depends on bdll_pkg.
module bdll_ctrl
  import bdll_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  state_t  state_r, state_nxt;
  status_t reply_r, reply_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      reply_r <= ST_INSERTED;
    end else begin
      state_r <= state_nxt;
      reply_r <= reply_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    reply_nxt = reply_r;
    cmd       = '0;
    cmd.rd_src     = RD_HEAD;
    cmd.out_status = reply_r;
    case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_fire) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.op)
          OP_HEAD_INS, OP_TAIL_INS: begin
            if (sts.list_full) begin
              reply_nxt = ST_FULL;
              state_nxt = S_REPLY;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_src = RD_FREE;
              state_nxt  = S_INS_WR;
            end
          end
          OP_DELETE: begin
            if (sts.list_empty) begin
              reply_nxt = ST_NOT_FOUND;
              state_nxt = S_REPLY;
            end else begin
              cmd.rd_en   = 1'b1;
              cmd.idx_clr = 1'b1;
              state_nxt   = S_DEL_CMP;
            end
          end
          default: begin
            if (sts.list_empty) begin
              reply_nxt = ST_DUMPED;
              state_nxt = S_REPLY;
            end else begin
              cmd.rd_en   = 1'b1;
              cmd.idx_clr = 1'b1;
              state_nxt   = S_DMP_OUT;
            end
          end
        endcase
      end
      S_INS_WR: begin
        cmd.do_insert = 1'b1;
        reply_nxt     = ST_INSERTED;
        state_nxt     = S_REPLY;
      end
      S_DEL_CMP: begin
        if (sts.match) begin
          cmd.do_unlink = 1'b1;
          state_nxt     = S_DEL_FREE;
        end else if (sts.walk_tail) begin
          reply_nxt = ST_NOT_FOUND;
          state_nxt = S_REPLY;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_src  = RD_NEXT;
          cmd.idx_inc = 1'b1;
        end
      end
      S_DEL_FREE: begin
        cmd.do_release = 1'b1;
        reply_nxt      = ST_DELETED;
        state_nxt      = S_REPLY;
      end
      S_DMP_OUT: begin
        if (sts.out_free) begin
          cmd.load_out   = 1'b1;
          cmd.out_record = 1'b1;
          cmd.out_status = ST_DUMPED;
          if (sts.walk_tail) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_src  = RD_NEXT;
            cmd.idx_inc = 1'b1;
          end
        end
      end
      S_REPLY: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/bounded_doubly_linked_list.sv
// Bounded doubly linked list: head/tail insert, delete by name, dump head to tail.
// Insert steps through decode, write and reply; delete walks from the head until a match or the
//   tail; dump gives its records head to tail, one per cycle while the result register is free.
// Throughput: one item at a time; the list walk does one linked-memory read per cycle
//   unless a dump waits on the result channel. Reset: synchronous, active low; clears
//   head, tail, free pointer, count and the forward-link valid bits; stores are not swept.
module bounded_doubly_linked_list
  import bdll_pkg::*;
#(
  parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TDATA_W-1:0]    in_tdata,   // name_low, name_mid, name_high, age_in
  input  logic [IN_USER_W-1:0]  in_tuser,   // opcode
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TDATA_W-1:0]    out_tdata,  // out_name_low, out_name_mid, out_name_high, age_out
  output logic [OUT_USER_W-1:0] out_tuser,  // status, entry_valid
  output logic                  out_tlast
);

  localparam int SLOT_W = $clog2(LIST_DEPTH);
  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);

  ctl_sts_t sts;
  ctl_cmd_t cmd;
  logic     in_fire;

  // list registers
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic [SLOT_W-1:0] free_r, free_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [LIST_DEPTH-1:0] fwd_ok_r, fwd_ok_nxt;  // forward link written since reset

  // latched item
  op_t               op_r;
  logic [NAME_W-1:0] key_r;
  logic [AGE_W-1:0]  age_r;

  // walk position: slot whose data sits on the RAM read ports
  logic [SLOT_W-1:0] cur_r;
  logic [CNT_W-1:0]  idx_r;

  // memory ports
  logic [SLOT_W-1:0] rd_addr;
  logic [REC_W-1:0]  rec_rd;
  logic [SLOT_W-1:0] fwd_rd, bwd_rd;
  logic              rec_we;
  logic              fwd_we, bwd_we;
  logic [SLOT_W-1:0] fwd_wa, fwd_wd, bwd_wa, bwd_wd;

  logic [SLOT_W-1:0] cur_next;
  logic [SLOT_W-1:0] fwd_eff;
  logic              walk_head;

  // output register
  logic                  out_valid_r;
  logic [TDATA_W-1:0]    out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;
  logic                  out_last_r;

  assign in_tready = cmd.in_ready & rst_n;
  assign in_fire   = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= op_t'(in_tuser);
      key_r <= in_tdata[NAME_W-1:0] & NAME_MASK;
      age_r <= in_tdata[REC_W-1:NAME_W];
    end
  end

  // An unwritten forward link is taken as the next slot, wrapping.
  assign cur_next  = (cur_r == SLOT_W'(LIST_DEPTH - 1)) ? '0 : cur_r + SLOT_W'(1);
  assign fwd_eff   = fwd_ok_r[cur_r] ? fwd_rd : cur_next;
  assign walk_head = (idx_r == '0);

  always_comb begin
    case (cmd.rd_src)
      RD_FREE: rd_addr = free_r;
      RD_HEAD: rd_addr = head_r;
      RD_NEXT: rd_addr = fwd_eff;
      default: rd_addr = head_r;
    endcase
  end

  always_comb begin
    sts.op         = op_r;
    sts.list_full  = (count_r == CNT_W'(LIST_DEPTH));
    sts.list_empty = (count_r == '0);
    sts.match      = (rec_rd[NAME_W-1:0] == key_r);
    sts.walk_tail  = ((idx_r + CNT_W'(1)) == count_r);
    sts.out_free   = ~out_valid_r | out_tready;
  end

  bdll_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Link updates. Each step writes each link memory at most once.
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    free_nxt   = free_r;
    count_nxt  = count_r;
    fwd_ok_nxt = fwd_ok_r;
    rec_we     = 1'b0;
    fwd_we     = 1'b0;
    bwd_we     = 1'b0;
    fwd_wa     = cur_r;
    fwd_wd     = cur_r;
    bwd_wa     = cur_r;
    bwd_wd     = cur_r;

    if (cmd.do_insert) begin
      // new slot is free_r, its old forward link is on fwd_eff
      rec_we    = 1'b1;
      free_nxt  = fwd_eff;
      count_nxt = count_r + CNT_W'(1);
      if (count_r == '0) begin
        fwd_we   = 1'b1;
        fwd_wa   = free_r;
        fwd_wd   = free_r;
        bwd_we   = 1'b1;
        bwd_wa   = free_r;
        bwd_wd   = free_r;
        head_nxt = free_r;
        tail_nxt = free_r;
      end else if (op_r == OP_HEAD_INS) begin
        fwd_we   = 1'b1;
        fwd_wa   = free_r;
        fwd_wd   = head_r;
        bwd_we   = 1'b1;
        bwd_wa   = head_r;
        bwd_wd   = free_r;
        head_nxt = free_r;
      end else begin
        bwd_we   = 1'b1;
        bwd_wa   = free_r;
        bwd_wd   = tail_r;
        fwd_we   = 1'b1;
        fwd_wa   = tail_r;
        fwd_wd   = free_r;
        tail_nxt = free_r;
      end
    end

    if (cmd.do_unlink) begin
      // matched slot cur_r: next on fwd_eff, previous on bwd_rd
      if (walk_head && sts.walk_tail) begin
        head_nxt = '0;
        tail_nxt = '0;
      end else if (walk_head) begin
        head_nxt = fwd_eff;
      end else if (sts.walk_tail) begin
        tail_nxt = bwd_rd;
        fwd_we   = 1'b1;
        fwd_wa   = bwd_rd;
        fwd_wd   = bwd_rd;
      end else begin
        fwd_we = 1'b1;
        fwd_wa = bwd_rd;
        fwd_wd = fwd_eff;
        bwd_we = 1'b1;
        bwd_wa = fwd_eff;
        bwd_wd = bwd_rd;
      end
    end

    if (cmd.do_release) begin
      // freed slot goes to the front of the free chain
      fwd_we    = 1'b1;
      fwd_wa    = cur_r;
      fwd_wd    = free_r;
      free_nxt  = cur_r;
      count_nxt = count_r - CNT_W'(1);
    end

    if (fwd_we) begin
      fwd_ok_nxt[fwd_wa] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      free_r   <= '0;
      count_r  <= '0;
      fwd_ok_r <= '0;
      idx_r    <= '0;
    end else begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      free_r   <= free_nxt;
      count_r  <= count_nxt;
      fwd_ok_r <= fwd_ok_nxt;
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      cur_r <= rd_addr;
    end
  end

  // record store: {age, name}
  bdll_ram #(.WIDTH(REC_W), .DEPTH(LIST_DEPTH)) u_rec_ram (
    .clk     (clk),
    .wr_en   (rec_we),
    .wr_addr (free_r),
    .wr_data ({age_r, key_r}),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rec_rd)
  );

  bdll_ram #(.WIDTH(SLOT_W), .DEPTH(LIST_DEPTH)) u_fwd_ram (
    .clk     (clk),
    .wr_en   (fwd_we),
    .wr_addr (fwd_wa),
    .wr_data (fwd_wd),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (fwd_rd)
  );

  bdll_ram #(.WIDTH(SLOT_W), .DEPTH(LIST_DEPTH)) u_bwd_ram (
    .clk     (clk),
    .wr_en   (bwd_we),
    .wr_addr (bwd_wa),
    .wr_data (bwd_wd),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (bwd_rd)
  );

  // Result register; a waiting result does not block the next accept.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (cmd.out_record) begin
        out_data_r <= TDATA_W'(rec_rd);
        out_user_r <= {1'b1, ST_DUMPED};
        out_last_r <= sts.walk_tail;
      end else begin
        out_data_r <= '0;
        out_user_r <= {1'b0, cmd.out_status};
        out_last_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: sv/bdll_chk.sv
// Port-level checker for the linked list, bound to the top level.
// Depends on bdll_pkg and bounded_doubly_linked_list.
module bdll_chk
  import bdll_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [TDATA_W-1:0]    in_tdata,
  input logic [IN_USER_W-1:0]  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [TDATA_W-1:0]    out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser,
  input logic                  out_tlast
);

  // no result pending right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // status-only results are single, zero-payload items
  a_reply_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[3] |-> out_tlast && (out_tdata == '0))
    else $error("status result with payload or without last");

  // records only come from a dump
  a_record_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |-> (out_tuser[2:0] == ST_DUMPED))
    else $error("record with wrong status");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while busy");

endmodule

bind bounded_doubly_linked_list bdll_chk u_bdll_chk (.*);
